>>> design/bandpass_biquad_cascade_unit_assert.svh
// ----------------------------------------------------------------------------
// bandpass biquad cascade assertion macros
// shared property forms used by the cascade unit checks
// ----------------------------------------------------------------------------
`ifndef BANDPASS_BIQUAD_CASCADE_UNIT_ASSERT_SVH
`define BANDPASS_BIQUAD_CASCADE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// widths, fixed-point constants, coefficient table and saturation helpers
// for the band-pass biquad cascade
// ----------------------------------------------------------------------------
package bbc_pkg;

   // field and state widths
   localparam int SAMPLE_W     = 12;
   localparam int FILT_W       = 24;
   localparam int STATE_W      = 48;
   localparam int SAMPLE_SHIFT = 16;
   localparam int OUT_SHIFT    = 8;

   // section count limits
   localparam int MAX_SECTIONS     = 8;
   localparam int DEFAULT_SECTIONS = 4;
   localparam int SEC_IDX_W        = 3;

   // multiplier and product widths (state split into two 24-bit halves)
   localparam int COEF_W     = 33;
   localparam int HALF_W     = 24;
   localparam int MUL_A_W    = HALF_W + 1;
   localparam int MUL_W      = MUL_A_W + COEF_W;
   localparam int FRAC_SHIFT = 30;
   localparam int PROD_W     = 81;
   localparam int RND_W      = PROD_W - FRAC_SHIFT;
   localparam int SUM_W      = 53;
   localparam int Q_W        = STATE_W + 1 - OUT_SHIFT;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_SHIFT - 1);
   localparam logic signed [STATE_W:0]  OUT_ROUND  = (STATE_W + 1)'(1) <<< (OUT_SHIFT - 1);

   // saturation bounds
   localparam logic signed [STATE_W-1:0] S48_MAX  = {1'b0, {(STATE_W - 1){1'b1}}};
   localparam logic signed [STATE_W-1:0] S48_MIN  = {1'b1, {(STATE_W - 1){1'b0}}};
   localparam logic signed [FILT_W-1:0]  FILT_MAX = {1'b0, {(FILT_W - 1){1'b1}}};
   localparam logic signed [FILT_W-1:0]  FILT_MIN = {1'b1, {(FILT_W - 1){1'b0}}};

   // Q2.30 coefficients, with one extra integer bit for the value two
   localparam logic signed [COEF_W-1:0] C_ZERO  = 33'sd0;
   localparam logic signed [COEF_W-1:0] C_ONE   = 33'sd1073741824;
   localparam logic signed [COEF_W-1:0] C_TWO   = 33'sd2147483648;
   localparam logic signed [COEF_W-1:0] C_NTWO  = -33'sd2147483648;
   localparam logic signed [COEF_W-1:0] C0_B0   = 33'sd301344752;
   localparam logic signed [COEF_W-1:0] C0_B1   = 33'sd602689503;
   localparam logic signed [COEF_W-1:0] C0_A1   = 33'sd758945235;
   localparam logic signed [COEF_W-1:0] C0_A2   = 33'sd167729532;
   localparam logic signed [COEF_W-1:0] C1_A1   = 33'sd1020357786;
   localparam logic signed [COEF_W-1:0] C1_A2   = 33'sd580605920;
   localparam logic signed [COEF_W-1:0] C2_A1   = -33'sd2097666161;
   localparam logic signed [COEF_W-1:0] C2_A2   = 33'sd1024601085;
   localparam logic signed [COEF_W-1:0] C3_A1   = -33'sd2126530199;
   localparam logic signed [COEF_W-1:0] C3_A2   = 33'sd1053462535;

   // product order within one section
   typedef enum logic [2:0] {
      SEL_A1,
      SEL_A2,
      SEL_B0,
      SEL_B1,
      SEL_B2
   } coef_sel_type;

   // coefficient for a section and product slot
   function automatic logic signed [COEF_W-1:0] coef_lookup(
      input logic [SEC_IDX_W-1:0] sec,
      input coef_sel_type         sel
   );
      logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
      b0 = C_ONE;
      b1 = C_ZERO;
      b2 = C_ZERO;
      a1 = C_ZERO;
      a2 = C_ZERO;
      case (sec)
         3'd0: begin
            b0 = C0_B0;
            b1 = C0_B1;
            b2 = C0_B0;
            a1 = C0_A1;
            a2 = C0_A2;
         end
         3'd1: begin
            b1 = C_TWO;
            b2 = C_ONE;
            a1 = C1_A1;
            a2 = C1_A2;
         end
         3'd2: begin
            b1 = C_NTWO;
            b2 = C_ONE;
            a1 = C2_A1;
            a2 = C2_A2;
         end
         3'd3: begin
            b1 = C_NTWO;
            b2 = C_ONE;
            a1 = C3_A1;
            a2 = C3_A2;
         end
         // extra sections pass their input through
         default: begin
            b0 = C_ONE;
         end
      endcase
      case (sel)
         SEL_A1:  return a1;
         SEL_A2:  return a2;
         SEL_B0:  return b0;
         SEL_B1:  return b1;
         SEL_B2:  return b2;
         default: return C_ZERO;
      endcase
   endfunction

   // clamp a running sum to the 48-bit state range
   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [SUM_W-1:0] v
   );
      if (v > SUM_W'(S48_MAX)) begin
         return S48_MAX;
      end else if (v < SUM_W'(S48_MIN)) begin
         return S48_MIN;
      end
      return v[STATE_W-1:0];
   endfunction

   // round Q32.16 half up to Q16.8 and clamp to the output range
   function automatic logic signed [FILT_W-1:0] round_out(
      input logic signed [STATE_W-1:0] v
   );
      logic signed [STATE_W:0] t;
      logic signed [Q_W-1:0]   q;
      t = (STATE_W + 1)'(v) + OUT_ROUND;
      q = t[STATE_W:OUT_SHIFT];
      if (q > Q_W'(FILT_MAX)) begin
         return FILT_MAX;
      end else if (q < Q_W'(FILT_MIN)) begin
         return FILT_MIN;
      end
      return q[FILT_W-1:0];
   endfunction

endpackage

>>> design/bandpass_biquad_cascade_unit.sv
// ----------------------------------------------------------------------------
// bandpass_biquad_cascade_unit
// band-pass as a cascade of SECTIONS direct-form-II biquads (eighth-order at four), computed
// with one shared 25x33 multiplier under a small sequencer
// ----------------------------------------------------------------------------
//
//  channel   ports                             moves
//  -------   -------------------------------   ------------------------------
//  request   req_valid req_stall req_sample    one 12-bit sample per transfer
//  response  rsp_valid rsp_stall rsp_filtered  one Q16.8 result per transfer
//
//  for each sample, every one of the five products per section is two
//  multiplier passes plus a merge and an accumulate, all through the single
//  shared multiplier, and each section adds two clamp steps.
//  reset clears the delay line, the sequencer and the response valid.
//  req_stall is high while a sample is in work; a finished result sits in the
//  response register, and a new sample may start while it waits to be taken.
//
`include "bandpass_biquad_cascade_unit_assert.svh"

module bandpass_biquad_cascade_unit
   import bbc_pkg::*;
#(
   parameter int SECTIONS = DEFAULT_SECTIONS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SAMPLE_W-1:0]      req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [FILT_W-1:0] rsp_filtered
);

   localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_WSTEP,
      ST_YSTEP,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      PH_LO,
      PH_HI,
      PH_MERGE,
      PH_ACC
   } phase_type;

   state_type    state_ff, state_in;
   phase_type    phase_ff, phase_in;
   coef_sel_type sel_ff, sel_in;
   logic [SEC_W-1:0] sec_ff, sec_in;

   logic signed [STATE_W-1:0] z1_ff [SECTIONS];
   logic signed [STATE_W-1:0] z1_in [SECTIONS];
   logic signed [STATE_W-1:0] z2_ff [SECTIONS];
   logic signed [STATE_W-1:0] z2_in [SECTIONS];

   logic signed [STATE_W-1:0] acc_ff, acc_in;
   logic signed [STATE_W-1:0] w_ff, w_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [MUL_W-1:0]   mul_ff, mul_in;
   logic signed [PROD_W-1:0]  part_ff, part_in;
   logic signed [RND_W-1:0]   rnd_ff, rnd_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [FILT_W-1:0]  rsp_filtered_ff, rsp_filtered_in;

   logic signed [STATE_W-1:0] operand;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [COEF_W-1:0]  coef;
   logic signed [PROD_W-1:0]  full_prod;
   logic signed [STATE_W-1:0] sum_sat;
   logic                      subtract;
   logic                      rsp_free;
   logic                      last_sec;

   // operand pick: delays of the head section or the fresh w
   always_comb begin
      case (sel_ff)
         SEL_A1, SEL_B1: operand = z1_ff[0];
         SEL_A2, SEL_B2: operand = z2_ff[0];
         SEL_B0:         operand = w_ff;
         default:        operand = z1_ff[0];
      endcase
   end

   // shared multiplier, low half unsigned then high half signed
   assign mul_a = (phase_ff == PH_LO) ? $signed({1'b0, operand[HALF_W-1:0]})
                                      : $signed({operand[STATE_W-1], operand[STATE_W-1:HALF_W]});
   assign coef  = coef_lookup(SEC_IDX_W'(sec_ff), sel_ff);
   assign mul_in = mul_a * coef;

   // recombine the halves and round half up
   assign full_prod = part_ff + (PROD_W'(mul_ff) <<< HALF_W);
   assign subtract  = (sel_ff == SEL_A1) || (sel_ff == SEL_A2);
   assign sum_sat   = sat_state(sum_ff);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign last_sec  = (sec_ff == SEC_W'(SECTIONS - 1));

   // sequencer next state
   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      sel_in          = sel_ff;
      sec_in          = sec_ff;
      z1_in           = z1_ff;
      z2_in           = z2_ff;
      acc_in          = acc_ff;
      w_in            = w_ff;
      sum_in          = sum_ff;
      part_in         = part_ff;
      rnd_in          = rnd_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_filtered_in = rsp_filtered_ff;

      case (state_ff)
         ST_IDLE: begin
            // sample transfer: load Q32.16 input and start section zero
            if (req_valid) begin
               acc_in   = STATE_W'({req_sample, {SAMPLE_SHIFT{1'b0}}});
               sum_in   = SUM_W'({req_sample, {SAMPLE_SHIFT{1'b0}}});
               sec_in   = '0;
               sel_in   = SEL_A1;
               phase_in = PH_LO;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            case (phase_ff)
               PH_LO: begin
                  phase_in = PH_HI;
               end
               PH_HI: begin
                  part_in  = PROD_W'(mul_ff) + ROUND_HALF;
                  phase_in = PH_MERGE;
               end
               PH_MERGE: begin
                  rnd_in   = full_prod[PROD_W-1:FRAC_SHIFT];
                  phase_in = PH_ACC;
               end
               PH_ACC: begin
                  sum_in   = subtract ? sum_ff - SUM_W'(rnd_ff) : sum_ff + SUM_W'(rnd_ff);
                  phase_in = PH_LO;
                  case (sel_ff)
                     SEL_A1:  sel_in = SEL_A2;
                     SEL_A2:  state_in = ST_WSTEP;
                     SEL_B0:  sel_in = SEL_B1;
                     SEL_B1:  sel_in = SEL_B2;
                     SEL_B2:  state_in = ST_YSTEP;
                     default: state_in = ST_IDLE;
                  endcase
               end
               default: phase_in = PH_LO;
            endcase
         end
         ST_WSTEP: begin
            // clamp w and restart the sum for the numerator
            w_in     = sum_sat;
            sum_in   = '0;
            sel_in   = SEL_B0;
            phase_in = PH_LO;
            state_in = ST_PROD;
         end
         ST_YSTEP: begin
            // clamp section output and rotate the delay line by one section
            acc_in = sum_sat;
            for (int i = 0; i < SECTIONS - 1; i++) begin
               z1_in[i] = z1_ff[i + 1];
               z2_in[i] = z2_ff[i + 1];
            end
            z1_in[SECTIONS - 1] = w_ff;
            z2_in[SECTIONS - 1] = z1_ff[0];
            if (last_sec) begin
               state_in = ST_OUTPUT;
            end else begin
               sec_in   = sec_ff + SEC_W'(1);
               sum_in   = SUM_W'(sum_sat);
               sel_in   = SEL_A1;
               phase_in = PH_LO;
               state_in = ST_PROD;
            end
         end
         ST_OUTPUT: begin
            // final rounding into the response register once it is free
            if (rsp_free) begin
               rsp_filtered_in = round_out(acc_ff);
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LO;
         sel_ff       <= SEL_A1;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SECTIONS; i++) begin
            z1_ff[i] <= '0;
            z2_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         sel_ff       <= sel_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
         z1_ff        <= z1_in;
         z2_ff        <= z2_in;
      end
      acc_ff          <= acc_in;
      w_ff            <= w_in;
      sum_ff          <= sum_in;
      mul_ff          <= mul_in;
      part_ff         <= part_in;
      rnd_ff          <= rnd_in;
      rsp_filtered_ff <= rsp_filtered_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   // checks on the sequencer
   `BBC_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, state_ff == ST_PROD && sec_ff == '0, "sample transfer did not start section zero")
   `BBC_ASSERT_NOW(a_wstep_slot, state_ff == ST_WSTEP, sel_ff == SEL_A2 && phase_ff == PH_LO, "w clamp outside the feedback slot")
   `BBC_ASSERT_NOW(a_ystep_slot, state_ff == ST_YSTEP, sel_ff == SEL_B2 && phase_ff == PH_LO, "output clamp outside the numerator slot")
   `BBC_ASSERT_NOW(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff == ST_OUTPUT), "response raised outside the output step")
   `BBC_ASSERT_NEXT(a_output_load, state_ff == ST_OUTPUT && rsp_free, rsp_valid_ff && state_ff == ST_IDLE, "free response register not loaded")

endmodule

>>> tb/tb_bandpass_biquad_cascade_unit.sv
// ----------------------------------------------------------------------------
// tb_bandpass_biquad_cascade_unit
// drives raw converter codes into the band-pass biquad cascade, predicts
// every filtered sample with a wide-integer copy of the fixed-point math and
// checks each response transfer in order under random bursts and stalls
// ----------------------------------------------------------------------------
module tb_bandpass_biquad_cascade_unit
   import bbc_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int SECTIONS      = DEFAULT_SECTIONS;
   localparam int SECTION_LIMIT = MAX_SECTIONS;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int PAUSE_AT      = 550;
   localparam int LONG_HOLD     = 700;
   localparam int DRAIN_CYCLES  = 200;
   localparam int CYCLE_LIMIT   = 5000000;

   // saturation bounds of the state and of the output
   localparam longint STATE_HI = 64'sd140737488355327;
   localparam longint STATE_LO = -64'sd140737488355328;
   localparam longint OUT_HI   = 64'sd8388607;
   localparam longint OUT_LO   = -64'sd8388608;

   typedef logic signed [95:0] wide_type;

   // product slots of one section
   typedef enum int {
      TAP_A1,
      TAP_A2,
      TAP_B0,
      TAP_B1,
      TAP_B2
   } tap_slot_type;

   // stimulus shapes for the random part
   typedef enum int {
      SRC_UNIFORM,
      SRC_WALK,
      SRC_RAIL,
      SRC_HOLD
   } source_kind_type;

   // receiver stall patterns
   typedef enum int {
      RX_FREE,
      RX_STALL,
      RX_CHATTER
   } rx_mode_type;

   typedef struct {
      logic                pause;
      logic [SAMPLE_W-1:0] code;
   } pending_item_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [SAMPLE_W-1:0]      req_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [FILT_W-1:0] rsp_filtered;

   pending_item_type         pending_q[$];
   logic signed [FILT_W-1:0] filtered_expect_q[$];
   logic signed [STATE_W-1:0] delay_line[2*SECTION_LIMIT];

   int  error_count    = 0;
   int  accepted_count = 0;
   int  result_count   = 0;
   int  cycle_count    = 0;
   bit  req_taken      = 1'b0;

   bandpass_biquad_cascade_unit #(
      .SECTIONS(SECTIONS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_filtered(rsp_filtered)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // coefficient of one section and slot, 30 fraction bits
   function automatic wide_type section_tap(input int sec, input tap_slot_type slot);
      longint b0, b1, b2, a1, a2;
      b0 = 64'sd1073741824;
      b1 = 0;
      b2 = 0;
      a1 = 0;
      a2 = 0;
      case (sec)
         0: begin
            b0 = 64'sd301344752;
            b1 = 64'sd602689503;
            b2 = 64'sd301344752;
            a1 = 64'sd758945235;
            a2 = 64'sd167729532;
         end
         1: begin
            b1 = 64'sd2147483648;
            b2 = 64'sd1073741824;
            a1 = 64'sd1020357786;
            a2 = 64'sd580605920;
         end
         2: begin
            b1 = -64'sd2147483648;
            b2 = 64'sd1073741824;
            a1 = -64'sd2097666161;
            a2 = 64'sd1024601085;
         end
         3: begin
            b1 = -64'sd2147483648;
            b2 = 64'sd1073741824;
            a1 = -64'sd2126530199;
            a2 = 64'sd1053462535;
         end
         default: begin
            b0 = 64'sd1073741824;
         end
      endcase
      case (slot)
         TAP_A1:  return wide_type'(a1);
         TAP_A2:  return wide_type'(a2);
         TAP_B0:  return wide_type'(b0);
         TAP_B1:  return wide_type'(b1);
         default: return wide_type'(b2);
      endcase
   endfunction

   // state value times coefficient, rounded half up back to 16 fraction bits
   function automatic wide_type scaled_product(input wide_type v, input wide_type c);
      wide_type p;
      p = v * c + (wide_type'(1) <<< 29);
      return p >>> 30;
   endfunction

   function automatic logic signed [STATE_W-1:0] clamp_state(input wide_type v);
      if (v > wide_type'(STATE_HI)) begin
         return STATE_HI[STATE_W-1:0];
      end else if (v < wide_type'(STATE_LO)) begin
         return STATE_LO[STATE_W-1:0];
      end
      return v[STATE_W-1:0];
   endfunction

   // one sample through the cascade, updating the delay line
   function logic signed [FILT_W-1:0] bandpass_predict(input logic [SAMPLE_W-1:0] code);
      wide_type acc, w, z1, z2, t;
      int       n;
      acc = wide_type'(code) <<< 16;
      n   = (SECTIONS > SECTION_LIMIT) ? SECTION_LIMIT : SECTIONS;
      for (int k = 0; k < n; k++) begin
         z1  = wide_type'(delay_line[2*k]);
         z2  = wide_type'(delay_line[2*k+1]);
         w   = wide_type'(clamp_state(acc - scaled_product(z1, section_tap(k, TAP_A1))
                                          - scaled_product(z2, section_tap(k, TAP_A2))));
         acc = wide_type'(clamp_state(scaled_product(w, section_tap(k, TAP_B0))
                                      + scaled_product(z1, section_tap(k, TAP_B1))
                                      + scaled_product(z2, section_tap(k, TAP_B2))));
         delay_line[2*k+1] = z1[STATE_W-1:0];
         delay_line[2*k]   = w[STATE_W-1:0];
      end
      t = (acc + wide_type'(128)) >>> 8;
      if (t > wide_type'(OUT_HI)) begin
         t = wide_type'(OUT_HI);
      end else if (t < wide_type'(OUT_LO)) begin
         t = wide_type'(OUT_LO);
      end
      return t[FILT_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at result %0d: %s got %0d want %0d", result_count, what, got, want);
      error_count++;
   endtask

   task automatic queue_code(input int code);
      pending_item_type it;
      it.pause = 1'b0;
      it.code  = code[SAMPLE_W-1:0];
      pending_q.push_back(it);
   endtask

   task automatic queue_pause();
      pending_item_type it;
      it.pause = 1'b1;
      it.code  = '0;
      pending_q.push_back(it);
   endtask

   // sample ports, check results and predict each accepted sample
   always @(posedge clock) begin : watch_ports
      logic signed [FILT_W-1:0] want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (filtered_expect_q.size() == 0) begin
               report_mismatch("unexpected transfer, filtered", longint'(rsp_filtered),
                               64'sd0);
            end else begin
               want = filtered_expect_q.pop_front();
               if (rsp_filtered !== want) begin
                  report_mismatch("filtered", longint'(rsp_filtered), longint'(want));
               end
            end
            result_count++;
         end
         if (req_taken) begin
            filtered_expect_q.push_back(bandpass_predict(req_sample));
            accepted_count++;
         end
      end
   end

   // sender: bursts with random gaps, pause items wait for the pipe to drain
   int burst_left = 0;
   int gap_left   = 0;
   bit draining   = 1'b0;

   always @(negedge clock) begin : drive_samples
      logic                next_valid;
      logic [SAMPLE_W-1:0] next_code;
      pending_item_type    it;
      next_valid = req_valid;
      next_code  = req_sample;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         next_valid = 1'b0;
         if (draining) begin
            if (filtered_expect_q.size() == 0) begin
               draining = 1'b0;
            end
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_q.size() > 0) begin
            it = pending_q.pop_front();
            if (it.pause) begin
               draining = 1'b1;
            end else begin
               next_valid = 1'b1;
               next_code  = it.code;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 180);
               end
            end
         end
      end
      req_valid  <= next_valid;
      req_sample <= next_code;
   end

   // receiver: random stall segments, plus long holds to back up the block
   int          hold_left    = 0;
   int          holds_done   = 0;
   int          segment_left = 0;
   rx_mode_type rx_mode      = RX_FREE;

   always @(negedge clock) begin : drive_stall
      logic next_stall;
      next_stall = 1'b0;
      if (!reset) begin
         if (hold_left == 0 && ((holds_done == 0 && accepted_count >= 60) ||
                                (holds_done == 1 && accepted_count >= 700))) begin
            hold_left = LONG_HOLD;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else begin
            if (segment_left == 0) begin
               case ($urandom_range(0, 3))
                  0, 1:    rx_mode = RX_FREE;
                  2:       rx_mode = RX_STALL;
                  default: rx_mode = RX_CHATTER;
               endcase
               segment_left = $urandom_range(1, 150);
            end
            segment_left--;
            case (rx_mode)
               RX_STALL:   next_stall = 1'b1;
               RX_CHATTER: next_stall = 1'($urandom_range(0, 1));
               default:    next_stall = 1'b0;
            endcase
         end
      end
      rsp_stall <= next_stall;
   end

   // timeout
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_bandpass_biquad_cascade_unit: errors");
         $finish;
      end
   end

   // stimulus, reset and end of run
   initial begin : main_sequence
      source_kind_type kind;
      int              made;
      int              run_len;
      int              level;
      int              code;

      for (int i = 0; i < 2*SECTION_LIMIT; i++) begin
         delay_line[i] = '0;
      end

      // directed: rails, steps, alternating full swings, bit patterns
      queue_code(0);
      queue_code(0);
      for (int i = 0; i < 4; i++) begin
         queue_code(4095);
      end
      queue_code(0);
      queue_code(0);
      for (int i = 0; i < 6; i++) begin
         queue_code((i % 2 == 0) ? 4095 : 0);
      end
      queue_code(2048);
      queue_code(2047);
      queue_code(1);
      queue_code(4094);
      queue_code(12'h555);
      queue_code(12'haaa);
      queue_code(4095);
      queue_code(4095);
      queue_code(0);
      queue_pause();

      // random: runs of uniform noise, random walks, rail swings and flats
      made  = 0;
      level = 2048;
      while (made < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       kind = SRC_UNIFORM;
            1:       kind = SRC_WALK;
            2:       kind = SRC_RAIL;
            default: kind = SRC_HOLD;
         endcase
         run_len = $urandom_range(4, 40);
         level   = $urandom_range(0, 4095);
         for (int j = 0; j < run_len && made < RANDOM_ITEMS; j++) begin
            case (kind)
               SRC_UNIFORM: code = $urandom_range(0, 4095);
               SRC_WALK: begin
                  level = level + int'($urandom_range(0, 400)) - 200;
                  if (level < 0) level = 0;
                  if (level > 4095) level = 4095;
                  code = level;
               end
               SRC_RAIL: code = ($urandom_range(0, 1) == 1) ? 4095 : 0;
               default:  code = level;
            endcase
            queue_code(code);
            made++;
            if (made == PAUSE_AT) begin
               queue_pause();
            end
         end
      end

      // reset
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for all stimulus, then all results, then let the pipe settle
      while (pending_q.size() != 0 || req_valid || draining) begin
         @(posedge clock);
      end
      while (filtered_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (filtered_expect_q.size() != 0) begin
         report_mismatch("missing transfer, filtered", 64'sd0, longint'(filtered_expect_q[0]));
      end

      if (error_count == 0) begin
         $display("tb_bandpass_biquad_cascade_unit: clean");
      end else begin
         $display("tb_bandpass_biquad_cascade_unit: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/bbc_pkg.sv
design/bandpass_biquad_cascade_unit.sv
tb/tb_bandpass_biquad_cascade_unit.sv
